// File: src/pbplru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbplru_pkg;

  localparam int NUM_FRAMES_DEF   = 64;
  localparam int FILE_ID_BITS_DEF = 16;
  localparam int PAGE_BITS_DEF    = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int PIN_W      = 8;

  localparam logic [PIN_W-1:0] PIN_FREE     = 8'd0;
  localparam logic [PIN_W-1:0] PIN_WRITER   = 8'd255;
  localparam logic [PIN_W-1:0] PIN_READ_MAX = 8'd126;

  // Release by file handles at most this many matching frames.
  localparam int RESULT_CAP = 64;
  localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_FETCH     = 3'd0,
    MODE_BEGIN_RD  = 3'd1,
    MODE_BEGIN_WR  = 3'd2,
    MODE_END_RD    = 3'd3,
    MODE_END_WR    = 3'd4,
    MODE_RELEASE   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_MISS    = 3'd1,
    ST_NOFRAME = 3'd2,
    ST_BUSY    = 3'd3,
    ST_BAD     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_IN_USE  = 1'd0,
    REG_EVICT_FROM_MRU = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_WALK,
    S_ACC,
    S_UNLINK,
    S_INST,
    S_APP1,
    S_APP2,
    S_RREAD,
    S_REVAL,
    S_FLUSH
  } state_e;

endpackage

`default_nettype wire

// File: src/pbplru_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pbplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/page_buffer_pool_lru_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame table of a page buffer pool with LRU/MRU replacement and per-frame
// reader/writer pins.
// Command channel: drive mode_i and the payload with start high; the item is
// taken at the edge where start is high and busy is low. busy is high while
// the item is worked on.
// Result channel: each result shows for one cycle with res_valid_o high; the
// final result of an item has last_o set. The receiver cannot stall the block.
// Config channel: cfg_ready_o is always high; write only while busy is low.
// Steps per command:
//   bad frame / unknown mode: result the cycle after start.
//   begin read/write: pin update; end read/write: pin update + relink.
//   fetch: tag scan (one frame per cycle through the tag RAM), ending on a hit;
//   on a miss, if the pool is full, a victim walk along the recency list (one
//   hop a cycle), then install and relink.
//   release file: frames are read and checked in turn, up to RESULT_CAP
//   matches; each frame freed is unlinked, and a flush step sends the final result if any frame matched.
// The link RAMs' one write port each sets the relink length.
// Reset empties the pool at once (valid flops cleared); the RAMs need no clear.
module page_buffer_pool_lru_top #(
  parameter int NUM_FRAMES   = pbplru_pkg::NUM_FRAMES_DEF,
  parameter int FILE_ID_BITS = pbplru_pkg::FILE_ID_BITS_DEF,
  parameter int PAGE_BITS    = pbplru_pkg::PAGE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [pbplru_pkg::MODE_W-1:0]       mode_i,
  input  wire logic [FILE_ID_BITS-1:0]             file_id_i,
  input  wire logic [PAGE_BITS-1:0]                page_number_i,
  input  wire logic [$clog2(NUM_FRAMES)-1:0]       frame_index_i,
  output      logic                                res_valid_o,
  output      logic [pbplru_pkg::STATUS_W-1:0]     status_o,
  output      logic [$clog2(NUM_FRAMES)-1:0]       frame_slot_o,
  output      logic                                evicted_o,
  output      logic                                writeback_o,
  output      logic [FILE_ID_BITS-1:0]             evicted_file_o,
  output      logic [PAGE_BITS-1:0]                evicted_page_o,
  output      logic                                last_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [pbplru_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pbplru_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import pbplru_pkg::*;

  localparam int SLOT_W = $clog2(NUM_FRAMES);
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int TAG_W  = FILE_ID_BITS + PAGE_BITS;
  localparam int META_W = PIN_W + 1;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_FRAMES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_FRAMES - 1);

  // Control and configuration registers
  state_e                  state_q, state_d;
  logic [NUM_FRAMES-1:0]   valid_q, valid_d;
  logic [CFG_DATA_W-1:0]   fiu_q;
  logic                    mru_q;
  logic [LINK_W-1:0]       oldest_q, oldest_d, newest_q, newest_d;
  logic [CNT_W-1:0]        used_q, used_d;
  mode_e                   mode_q, mode_d;
  logic [SLOT_W-1:0]       scan_q, scan_d, steps_q, steps_d, tgt_q, tgt_d;
  logic                    free_found_q, free_found_d;
  logic [SLOT_W-1:0]       free_idx_q, free_idx_d;
  logic                    rel_end_q, rel_end_d;
  logic [RCNT_W-1:0]       rcnt_q, rcnt_d;
  logic                    pend_v_q, pend_v_d;
  logic                    res_valid_q, res_valid_d;

  // Payload registers
  logic [FILE_ID_BITS-1:0] file_q, file_d;
  logic [PAGE_BITS-1:0]    page_q, page_d;
  logic [LINK_W-1:0]       o_q, o_d, n_q, n_d;
  status_e                 res_st_q, res_st_d, pend_st_q, pend_st_d;
  logic [SLOT_W-1:0]       res_slot_q, res_slot_d, pend_slot_q, pend_slot_d;
  logic                    res_ev_q, res_ev_d, pend_ev_q, pend_ev_d;
  logic                    res_wb_q, res_wb_d, pend_wb_q, pend_wb_d;
  logic [FILE_ID_BITS-1:0] res_file_q, res_file_d, pend_file_q, pend_file_d;
  logic [PAGE_BITS-1:0]    res_page_q, res_page_d, pend_page_q, pend_page_d;
  logic                    res_last_q, res_last_d;

  // RAM ports
  logic [SLOT_W-1:0] rd_addr;
  logic [TAG_W-1:0]  tag_rd, tag_wdata;
  logic [META_W-1:0] meta_rd, meta_wdata;
  logic [LINK_W-1:0] older_rd, newer_rd, older_wdata, newer_wdata;
  logic              tag_we, meta_we, older_we, newer_we;
  logic [SLOT_W-1:0] meta_waddr, older_waddr, newer_waddr;

  pbplru_ram #(.WIDTH(TAG_W), .DEPTH(NUM_FRAMES)) u_tag_ram (
    .clk_i, .we_i(tag_we), .waddr_i(tgt_q), .wdata_i(tag_wdata),
    .raddr_i(rd_addr), .rdata_o(tag_rd)
  );
  pbplru_ram #(.WIDTH(META_W), .DEPTH(NUM_FRAMES)) u_meta_ram (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .raddr_i(rd_addr), .rdata_o(meta_rd)
  );
  pbplru_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_older_ram (
    .clk_i, .we_i(older_we), .waddr_i(older_waddr), .wdata_i(older_wdata),
    .raddr_i(rd_addr), .rdata_o(older_rd)
  );
  pbplru_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_newer_ram (
    .clk_i, .we_i(newer_we), .waddr_i(newer_waddr), .wdata_i(newer_wdata),
    .raddr_i(rd_addr), .rdata_o(newer_rd)
  );

  // Shared decode
  logic [31:0]       cap32;
  logic [CNT_W-1:0]  cap;
  logic [PIN_W-1:0]  pin_rd;
  logic              dirty_rd;
  logic              accept, fi_ok, hit, free_here, free_any, scan_last;
  logic [SLOT_W-1:0] free_now;
  logic [LINK_W-1:0] walk_start, walk_next;
  logic              walk_pin0, walk_fail;
  logic              rel_match, rel_pinned, rel_end_now;
  logic              acc_ok, acc_relink;
  status_e           acc_st;
  logic [PIN_W-1:0]  acc_pin;
  logic              acc_dirty;

  always_comb begin
    cap32 = 32'(fiu_q);
    if (cap32 == 32'd0) begin
      cap32 = 32'd1;
    end
    if (cap32 > 32'(NUM_FRAMES)) begin
      cap32 = 32'(NUM_FRAMES);
    end
  end
  assign cap = cap32[CNT_W-1:0];

  assign pin_rd    = meta_rd[PIN_W-1:0];
  assign dirty_rd  = meta_rd[PIN_W];
  assign accept    = start && !busy;
  assign fi_ok     = (32'(frame_index_i) < 32'(NUM_FRAMES)) && valid_q[frame_index_i];
  assign scan_last = (scan_q == LAST_SLOT);
  assign hit       = valid_q[scan_q] && (tag_rd == {file_q, page_q});
  assign free_here = !valid_q[scan_q] && (CNT_W'(scan_q) < cap);
  assign free_any  = free_found_q || free_here;
  assign free_now  = free_found_q ? free_idx_q : scan_q;
  assign walk_start = mru_q ? newest_q : oldest_q;
  assign walk_pin0  = (pin_rd == PIN_FREE);
  assign walk_next  = mru_q ? older_rd : newer_rd;
  assign walk_fail  = (walk_next >= LINK_NONE) || (steps_q == LAST_SLOT);
  assign rel_match  = valid_q[scan_q] && (tag_rd[TAG_W-1:PAGE_BITS] == file_q);
  assign rel_pinned = (pin_rd != PIN_FREE);
  assign rel_end_now = scan_last ||
                       (rel_match && (rcnt_q == RCNT_W'(RESULT_CAP - 1)));

  // Pin rules for begin/end access
  always_comb begin
    acc_st     = ST_OK;
    acc_pin    = pin_rd;
    acc_dirty  = dirty_rd;
    acc_relink = 1'b0;
    case (mode_q)
      MODE_BEGIN_RD: begin
        if (pin_rd == PIN_WRITER || pin_rd >= PIN_READ_MAX) acc_st = ST_BUSY;
        else acc_pin = pin_rd + 8'd1;
      end
      MODE_BEGIN_WR: begin
        if (pin_rd != PIN_FREE) acc_st = ST_BUSY;
        else acc_pin = PIN_WRITER;
      end
      MODE_END_RD: begin
        if (pin_rd == PIN_FREE || pin_rd == PIN_WRITER) acc_st = ST_BAD;
        else begin
          acc_pin    = pin_rd - 8'd1;
          acc_relink = 1'b1;
        end
      end
      MODE_END_WR: begin
        if (pin_rd != PIN_WRITER) acc_st = ST_BAD;
        else begin
          acc_pin    = PIN_FREE;
          acc_dirty  = 1'b1;
          acc_relink = 1'b1;
        end
      end
      default: acc_st = ST_BAD;
    endcase
  end
  assign acc_ok = (acc_st == ST_OK);

  // RAM read address: fetch scan steps one entry a cycle, walk follows links
  always_comb begin
    case (state_q)
      S_IDLE:   rd_addr = (mode_e'(mode_i) == MODE_FETCH) ? '0 : frame_index_i;
      S_LOOKUP: rd_addr = scan_last ? walk_start[SLOT_W-1:0] : scan_q + 1'b1;
      S_WALK:   rd_addr = walk_next[SLOT_W-1:0];
      default:  rd_addr = scan_q;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_e'(mode_i))
            MODE_FETCH:   state_d = S_LOOKUP;
            MODE_RELEASE: state_d = S_RREAD;
            default: begin
              if (mode_e'(mode_i) inside {[MODE_BEGIN_RD:MODE_END_WR]} && fi_ok) begin
                state_d = S_ACC;
              end
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit) state_d = S_IDLE;
        else if (scan_last) begin
          if (used_q < cap) state_d = free_any ? S_INST : S_IDLE;
          else state_d = (walk_start < LINK_NONE) ? S_WALK : S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_pin0) state_d = S_UNLINK;
        else if (walk_fail) state_d = S_IDLE;
      end
      S_ACC:    state_d = (acc_ok && acc_relink) ? S_UNLINK : S_IDLE;
      S_UNLINK: begin
        case (mode_q)
          MODE_FETCH:   state_d = S_INST;
          MODE_RELEASE: state_d = rel_end_q ? S_FLUSH : S_RREAD;
          default:      state_d = S_APP1;
        endcase
      end
      S_INST:  state_d = S_APP1;
      S_APP1:  state_d = S_APP2;
      S_APP2:  state_d = S_IDLE;
      S_RREAD: state_d = S_REVAL;
      S_REVAL: begin
        if (rel_match && !rel_pinned) state_d = S_UNLINK;
        else state_d = rel_end_now ? S_FLUSH : S_RREAD;
      end
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM writes
  always_comb begin
    valid_d = valid_q;   oldest_d = oldest_q;  newest_d = newest_q;
    used_d = used_q;     mode_d = mode_q;      scan_d = scan_q;
    steps_d = steps_q;   tgt_d = tgt_q;        free_found_d = free_found_q;
    free_idx_d = free_idx_q; rel_end_d = rel_end_q; rcnt_d = rcnt_q;
    pend_v_d = pend_v_q; file_d = file_q;      page_d = page_q;
    o_d = o_q;           n_d = n_q;
    res_valid_d = 1'b0;
    res_st_d = res_st_q;     res_slot_d = res_slot_q; res_ev_d = res_ev_q;
    res_wb_d = res_wb_q;     res_file_d = res_file_q; res_page_d = res_page_q;
    res_last_d = res_last_q;
    pend_st_d = pend_st_q;   pend_slot_d = pend_slot_q; pend_ev_d = pend_ev_q;
    pend_wb_d = pend_wb_q;   pend_file_d = pend_file_q; pend_page_d = pend_page_q;
    tag_we = 1'b0;   tag_wdata = {file_q, page_q};
    meta_we = 1'b0;  meta_waddr = tgt_q;  meta_wdata = '0;
    older_we = 1'b0; older_waddr = tgt_q; older_wdata = newest_q;
    newer_we = 1'b0; newer_waddr = tgt_q; newer_wdata = LINK_NONE;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = mode_e'(mode_i);
          file_d = file_id_i;
          page_d = page_number_i;
          tgt_d = frame_index_i;
          scan_d = '0;
          steps_d = '0;
          free_found_d = 1'b0;
          rel_end_d = 1'b0;
          rcnt_d = '0;
          pend_v_d = 1'b0;
          // Clear result fields; mode cases below fill what they need
          res_st_d = ST_BAD;  res_slot_d = '0;  res_ev_d = 1'b0;
          res_wb_d = 1'b0;    res_file_d = '0;  res_page_d = '0;
          res_last_d = 1'b1;
          if (mode_e'(mode_i) inside {[MODE_BEGIN_RD:MODE_END_WR]}) begin
            res_slot_d = frame_index_i;
            res_valid_d = !fi_ok;
          end else if (!(mode_e'(mode_i) inside {MODE_FETCH, MODE_RELEASE})) begin
            res_valid_d = 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        scan_d = scan_q + 1'b1;
        if (free_here && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d = scan_q;
        end
        if (hit) begin
          res_st_d = ST_OK;
          res_slot_d = scan_q;
          res_valid_d = 1'b1;
        end else if (scan_last) begin
          if (used_q < cap) begin
            if (free_any) begin
              tgt_d = free_now;
              res_st_d = ST_MISS;
              res_slot_d = free_now;
            end else begin
              res_st_d = ST_NOFRAME;
              res_valid_d = 1'b1;
            end
          end else if (walk_start < LINK_NONE) begin
            tgt_d = walk_start[SLOT_W-1:0];
            steps_d = '0;
          end else begin
            res_st_d = ST_NOFRAME;
            res_valid_d = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (walk_pin0) begin
          // Victim found: keep its links and identity for the report
          o_d = older_rd;
          n_d = newer_rd;
          res_st_d = ST_MISS;
          res_slot_d = tgt_q;
          res_ev_d = 1'b1;
          res_wb_d = dirty_rd;
          res_file_d = tag_rd[TAG_W-1:PAGE_BITS];
          res_page_d = tag_rd[PAGE_BITS-1:0];
        end else if (walk_fail) begin
          res_st_d = ST_NOFRAME;
          res_valid_d = 1'b1;
        end else begin
          tgt_d = walk_next[SLOT_W-1:0];
          steps_d = steps_q + 1'b1;
        end
      end
      S_ACC: begin
        o_d = older_rd;
        n_d = newer_rd;
        res_st_d = acc_st;
        if (acc_ok) begin
          meta_we = 1'b1;
          meta_wdata = {acc_dirty, acc_pin};
        end
        res_valid_d = !(acc_ok && acc_relink);
      end
      S_UNLINK: begin
        if (n_q < LINK_NONE) begin
          older_we = 1'b1;
          older_waddr = n_q[SLOT_W-1:0];
          older_wdata = o_q;
        end else begin
          newest_d = o_q;
        end
        if (o_q < LINK_NONE) begin
          newer_we = 1'b1;
          newer_waddr = o_q[SLOT_W-1:0];
          newer_wdata = n_q;
        end else begin
          oldest_d = n_q;
        end
        if (mode_q == MODE_RELEASE) begin
          valid_d[tgt_q] = 1'b0;
          used_d = used_q - 1'b1;
        end
      end
      S_INST: begin
        tag_we = 1'b1;
        meta_we = 1'b1;
        meta_wdata = '0;
        valid_d[tgt_q] = 1'b1;
        // Eviction frees and refills the same frame: count unchanged
        if (!res_ev_q) used_d = used_q + 1'b1;
      end
      S_APP1: begin
        older_we = 1'b1;
        older_wdata = newest_q;
        if (newest_q < LINK_NONE) begin
          newer_we = 1'b1;
          newer_waddr = newest_q[SLOT_W-1:0];
          newer_wdata = {1'b0, tgt_q};
        end
      end
      S_APP2: begin
        newer_we = 1'b1;
        newer_wdata = LINK_NONE;
        newest_d = {1'b0, tgt_q};
        if (oldest_q >= LINK_NONE) oldest_d = {1'b0, tgt_q};
        res_valid_d = 1'b1;
      end
      S_REVAL: begin
        scan_d = scan_q + 1'b1;
        rel_end_d = rel_end_now;
        if (rel_match) begin
          rcnt_d = rcnt_q + 1'b1;
          // Send the held result now that another follows
          if (pend_v_q) begin
            res_st_d = pend_st_q;     res_slot_d = pend_slot_q;
            res_ev_d = pend_ev_q;     res_wb_d = pend_wb_q;
            res_file_d = pend_file_q; res_page_d = pend_page_q;
            res_last_d = 1'b0;
            res_valid_d = 1'b1;
          end
          pend_v_d = 1'b1;
          pend_slot_d = scan_q;
          tgt_d = scan_q;
          o_d = older_rd;
          n_d = newer_rd;
          if (rel_pinned) begin
            pend_st_d = ST_BUSY;  pend_ev_d = 1'b0;  pend_wb_d = 1'b0;
            pend_file_d = '0;     pend_page_d = '0;
          end else begin
            pend_st_d = ST_OK;    pend_ev_d = 1'b1;  pend_wb_d = dirty_rd;
            pend_file_d = tag_rd[TAG_W-1:PAGE_BITS];
            pend_page_d = tag_rd[PAGE_BITS-1:0];
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          res_st_d = pend_st_q;     res_slot_d = pend_slot_q;
          res_ev_d = pend_ev_q;     res_wb_d = pend_wb_q;
          res_file_d = pend_file_q; res_page_d = pend_page_q;
          res_last_d = 1'b1;
          res_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      fiu_q <= CFG_DATA_W'(NUM_FRAMES_DEF);
      mru_q <= 1'b0;
      oldest_q <= LINK_NONE;
      newest_q <= LINK_NONE;
      used_q <= '0;
      mode_q <= MODE_FETCH;
      scan_q <= '0;
      steps_q <= '0;
      tgt_q <= '0;
      free_found_q <= 1'b0;
      free_idx_q <= '0;
      rel_end_q <= 1'b0;
      rcnt_q <= '0;
      pend_v_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      used_q <= used_d;
      mode_q <= mode_d;
      scan_q <= scan_d;
      steps_q <= steps_d;
      tgt_q <= tgt_d;
      free_found_q <= free_found_d;
      free_idx_q <= free_idx_d;
      rel_end_q <= rel_end_d;
      rcnt_q <= rcnt_d;
      pend_v_q <= pend_v_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAMES_IN_USE:  fiu_q <= cfg_data_i;
          REG_EVICT_FROM_MRU: mru_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    file_d_hold: begin
      file_q <= file_d;
      page_q <= page_d;
      o_q <= o_d;
      n_q <= n_d;
      res_st_q <= res_st_d;
      res_slot_q <= res_slot_d;
      res_ev_q <= res_ev_d;
      res_wb_q <= res_wb_d;
      res_file_q <= res_file_d;
      res_page_q <= res_page_d;
      res_last_q <= res_last_d;
      pend_st_q <= pend_st_d;
      pend_slot_q <= pend_slot_d;
      pend_ev_q <= pend_ev_d;
      pend_wb_q <= pend_wb_d;
      pend_file_q <= pend_file_d;
      pend_page_q <= pend_page_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign res_valid_o    = res_valid_q;
  assign status_o       = res_st_q;
  assign frame_slot_o   = res_slot_q;
  assign evicted_o      = res_ev_q;
  assign writeback_o    = res_wb_q;
  assign evicted_file_o = res_file_q;
  assign evicted_page_o = res_page_q;
  assign last_o         = res_last_q;

  // Fill count tracks the valid flops
  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) == $countones(valid_q))
    else $error("frame count differs from valid frames");

  // Recency list ends are empty together
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q == LINK_NONE) == (newest_q == LINK_NONE))
    else $error("recency list head and tail disagree");

  // Only release-by-file yields results that are not final
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_last_q |-> mode_q == MODE_RELEASE)
    else $error("non-final result outside release");

  // An accepted item either answers at once or keeps the block busy
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && state_q == S_IDLE |=> res_valid_q || state_q != S_IDLE)
    else $error("accepted item dropped");

endmodule

`default_nettype wire
